// ----- rtl/core/cilp_pkg.sv -----
// types, codes and constants of the integer literal parser
// no dependencies; imported by every module under rtl/core
package cilp_pkg;

   localparam int unsigned ValueWidth = 64;
   localparam int unsigned SumWidth   = ValueWidth + 4;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_DIGITS = 2'd2,
      PH_SUFFIX = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      LP_NONE  = 2'd0,
      LP_LOWER = 2'd1,
      LP_UPPER = 2'd2
   } lpend_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_TOO_LARGE = 2'd2
   } status_type;

   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_7    = 8'h37;
   localparam logic [7:0] CH_9    = 8'h39;
   localparam logic [7:0] CH_UP_A = 8'h41;
   localparam logic [7:0] CH_UP_F = 8'h46;
   localparam logic [7:0] CH_UP_L = 8'h4C;
   localparam logic [7:0] CH_UP_U = 8'h55;
   localparam logic [7:0] CH_UP_X = 8'h58;
   localparam logic [7:0] CH_LO_A = 8'h61;
   localparam logic [7:0] CH_LO_F = 8'h66;
   localparam logic [7:0] CH_LO_L = 8'h6C;
   localparam logic [7:0] CH_LO_U = 8'h75;
   localparam logic [7:0] CH_LO_X = 8'h78;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_word_type;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  unsigned_flag;
      status_type            status;
   } rsp_word_type;

   typedef struct packed {
      logic [ValueWidth-1:0] acc;
      radix_type             radix;
      phase_type             phase;
      logic                  saw_u;
      logic                  saw_l;
      lpend_type             l_pend;
      logic                  overflow;
      logic                  bad;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      acc:      '0,
      radix:    RADIX_DEC,
      phase:    PH_FIRST,
      saw_u:    1'b0,
      saw_l:    1'b0,
      l_pend:   LP_NONE,
      overflow: 1'b0,
      bad:      1'b0
   };

endpackage

// ----- rtl/core/cilp_in_stage.sv -----
// input register of the parser: holds one accepted character word
// depends on cilp_pkg
module cilp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cilp_pkg::req_word_type req_word,
   input  logic                  advance,
   output logic                  held_valid,
   output cilp_pkg::req_word_type held_word
);
   import cilp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

   assign held_valid = valid_ff;
   assign held_word  = word_ff;

endmodule

// ----- rtl/core/cilp_step.sv -----
// one character step: next parse state and the result of a final character
// depends on cilp_pkg
module cilp_step (
   input  cilp_pkg::parse_state_type state_cur,
   input  cilp_pkg::req_word_type    word,
   output cilp_pkg::parse_state_type state_nxt,
   output cilp_pkg::rsp_word_type    result
);
   import cilp_pkg::*;

   logic [7:0]          ch;
   radix_type           eff_radix;
   logic                dig_ok;
   logic [3:0]          dval;
   logic [SumWidth-1:0] scaled;
   logic [SumWidth-1:0] sum;
   logic                do_digit;
   logic                do_suffix;
   lpend_type           pend;
   parse_state_type     upd;

   assign ch        = word.char_code;
   assign eff_radix = (state_cur.phase == PH_FIRST) ? RADIX_DEC : state_cur.radix;

   // digit decode against the radix in force for this character
   always_comb begin
      dig_ok = 1'b0;
      dval   = '0;
      if (ch inside {[CH_0:CH_9]}) begin
         dval   = ch[3:0];
         dig_ok = (eff_radix != RADIX_OCT) || (ch <= CH_7);
      end else if (eff_radix == RADIX_HEX && (ch inside {[CH_LO_A:CH_LO_F]})) begin
         dval   = 4'(ch - CH_LO_A + 8'd10);
         dig_ok = 1'b1;
      end else if (eff_radix == RADIX_HEX && (ch inside {[CH_UP_A:CH_UP_F]})) begin
         dval   = 4'(ch - CH_UP_A + 8'd10);
         dig_ok = 1'b1;
      end
   end

   always_comb begin
      case (eff_radix)
         RADIX_HEX: scaled = {state_cur.acc, 4'b0000};
         RADIX_OCT: scaled = {1'b0, state_cur.acc, 3'b000};
         default:   scaled = {3'b000, state_cur.acc, 1'b0} + {1'b0, state_cur.acc, 3'b000};
      endcase
      sum = scaled + SumWidth'(dval);
   end

   // next state
   always_comb begin
      upd       = state_cur;
      do_digit  = 1'b0;
      do_suffix = 1'b0;
      pend      = LP_NONE;
      if (!state_cur.bad) begin
         case (state_cur.phase)
            PH_FIRST: begin
               if (ch == CH_0 && !word.is_last) begin
                  upd.radix = RADIX_OCT;
                  upd.phase = PH_SECOND;
               end else begin
                  upd.radix = RADIX_DEC;
                  upd.phase = PH_DIGITS;
                  do_digit  = 1'b1;
               end
            end
            PH_SECOND: begin
               if ((ch == CH_LO_X || ch == CH_UP_X) && !word.is_last) begin
                  upd.radix = RADIX_HEX;
                  upd.phase = PH_DIGITS;
               end else begin
                  upd.phase = PH_DIGITS;
                  do_digit  = 1'b1;
               end
            end
            PH_DIGITS: begin
               do_digit = 1'b1;
            end
            default: begin
               do_suffix = 1'b1;
            end
         endcase
      end
      if (do_digit) begin
         if (dig_ok) begin
            upd.acc = sum[ValueWidth-1:0];
            if (sum[SumWidth-1:ValueWidth] != '0) begin
               upd.overflow = 1'b1;
            end
         end else begin
            upd.phase = PH_SUFFIX;
            do_suffix = 1'b1;
         end
      end
      if (do_suffix) begin
         pend       = state_cur.l_pend;
         upd.l_pend = LP_NONE;
         if ((pend == LP_LOWER && ch == CH_LO_L) || (pend == LP_UPPER && ch == CH_UP_L)) begin
            upd.l_pend = LP_NONE;
         end else if ((ch == CH_LO_U || ch == CH_UP_U) && !state_cur.saw_u) begin
            upd.saw_u = 1'b1;
         end else if ((ch == CH_LO_L || ch == CH_UP_L) && !state_cur.saw_l) begin
            upd.saw_l  = 1'b1;
            upd.l_pend = (ch == CH_LO_L) ? LP_LOWER : LP_UPPER;
         end else begin
            upd.bad = 1'b1;
         end
      end
      state_nxt = word.is_last ? STATE_RESET : upd;
   end

   // result of the token, used only on its final character
   always_comb begin
      if (upd.bad) begin
         result.value         = '0;
         result.unsigned_flag = 1'b0;
         result.status        = ST_INVALID;
      end else begin
         result.value         = upd.acc;
         result.unsigned_flag = upd.saw_u || upd.acc[ValueWidth-1];
         result.status        = upd.overflow ? ST_TOO_LARGE : ST_OK;
      end
   end

endmodule

// ----- rtl/core/cilp_out_stage.sv -----
// result register of the parser: holds one word until the sink takes it
// depends on cilp_pkg
module cilp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  cilp_pkg::rsp_word_type result,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cilp_pkg::rsp_word_type rsp_word
);
   import cilp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ----- rtl/core/c_integer_literal_parser_core.sv -----
// top level of the c integer literal parser: parse state and the two stages
// depends on cilp_pkg, cilp_in_stage, cilp_step, cilp_out_stage
//
//   channel   direction   ports                            word
//   request   in          req_valid  req_stall  req_word   one character, last mark
//   response  out         rsp_valid  rsp_stall  rsp_word   value, unsigned flag, status
//
// one character word per cycle while req_stall is low; a final character passes the input register,
// then the result register, before its result is valid
// the rate is set by the parse state register, updated by one multiply-add a cycle while a character advances
// reset clears the parse state and both valid flags
// a stalled result holds back only a final character waiting behind it
module c_integer_literal_parser_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cilp_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cilp_pkg::rsp_word_type rsp_word
);
   import cilp_pkg::*;

   logic            held_valid;
   req_word_type    held_word;
   logic            advance;
   logic            load_rsp;
   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type step_nxt;
   rsp_word_type    step_result;

   cilp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .advance    (advance),
      .held_valid (held_valid),
      .held_word  (held_word)
   );

   cilp_step u_step (
      .state_cur (state_ff),
      .word      (held_word),
      .state_nxt (step_nxt),
      .result    (step_result)
   );

   assign advance  = held_valid && (!held_word.is_last || !rsp_valid || !rsp_stall);
   assign load_rsp = advance && held_word.is_last;
   assign state_in = advance ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   cilp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (load_rsp),
      .result    (step_result),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // a final character always leaves the parse state clean for the next token
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (state_ff.phase == PH_FIRST && !state_ff.bad && state_ff.acc == '0))
      else $error("parse state not cleared after final character");

   // an invalid token reports zero and signed
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == ST_INVALID) |->
         (rsp_word.value == '0 && !rsp_word.unsigned_flag))
      else $error("invalid token with nonzero value");

   // a value above the signed maximum is flagged unsigned
   a_big_unsigned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.value[ValueWidth-1]) |-> rsp_word.unsigned_flag)
      else $error("large value not flagged unsigned");

endmodule

// ----- sim/tb_c_integer_literal_parser_core.sv -----
// testbench of c_integer_literal_parser_core: character words in, one constant per token out
// depends on cilp_pkg and the core; predicts every constant and checks it field by field
`timescale 1ns / 100ps

module tb_c_integer_literal_parser_core;
   import cilp_pkg::*;

   typedef logic [7:0] char_q_type[$];

   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned HoldOffCycles = 250;
   localparam logic [ValueWidth-1:0] SignedMax = 64'h7FFF_FFFF_FFFF_FFFF;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   rsp_word_type expected_constants[$];
   int unsigned  failures = 0;
   int unsigned  chars_sent = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  rsp_stall_pct = 0;
   int unsigned  hold_requests = 0;
   int unsigned  holds_served = 0;
   int unsigned  hold_left = 0;

   // parse state of the predictor
   logic [ValueWidth-1:0] acc_q = '0;
   radix_type             radix_q = RADIX_DEC;
   phase_type             phase_q = PH_FIRST;
   logic                  saw_u_q = 1'b0;
   logic                  saw_l_q = 1'b0;
   lpend_type             lpend_q = LP_NONE;
   logic                  ovf_q = 1'b0;
   logic                  bad_q = 1'b0;

   string extreme_texts[9] = '{
      "18446744073709551615", "18446744073709551616", "9223372036854775807",
      "9223372036854775808", "0xffffffffffffffff", "0X10000000000000000",
      "01777777777777777777777", "02000000000000000000000", "99999999999999999999999"
   };

   c_integer_literal_parser_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void take_suffix_char(logic [7:0] ch);
      lpend_type pending;
      pending = lpend_q;
      lpend_q = LP_NONE;
      if ((pending == LP_LOWER && ch == CH_LO_L) || (pending == LP_UPPER && ch == CH_UP_L))
         return;
      if ((ch == CH_LO_U || ch == CH_UP_U) && !saw_u_q) begin
         saw_u_q = 1'b1;
      end else if ((ch == CH_LO_L || ch == CH_UP_L) && !saw_l_q) begin
         saw_l_q = 1'b1;
         lpend_q = (ch == CH_LO_L) ? LP_LOWER : LP_UPPER;
      end else begin
         bad_q = 1'b1;
      end
   endfunction

   function automatic void take_digit_char(logic [7:0] ch);
      logic [ValueWidth-1:0] base;
      logic [ValueWidth-1:0] digit;
      logic                  is_digit;
      base = (radix_q == RADIX_HEX) ? 64'd16 : (radix_q == RADIX_OCT) ? 64'd8 : 64'd10;
      is_digit = 1'b1;
      digit = '0;
      if (ch >= CH_0 && ch <= CH_9)
         digit = 64'(ch - CH_0);
      else if (radix_q == RADIX_HEX && ch >= CH_LO_A && ch <= CH_LO_F)
         digit = 64'(ch - CH_LO_A + 8'd10);
      else if (radix_q == RADIX_HEX && ch >= CH_UP_A && ch <= CH_UP_F)
         digit = 64'(ch - CH_UP_A + 8'd10);
      else
         is_digit = 1'b0;
      if (!is_digit || digit >= base) begin
         phase_q = PH_SUFFIX;
         take_suffix_char(ch);
         return;
      end
      if (acc_q > (~64'd0 - digit) / base)
         ovf_q = 1'b1;
      acc_q = acc_q * base + digit;
   endfunction

   function automatic void parse_char(req_word_type w);
      if (!bad_q) begin
         case (phase_q)
            PH_FIRST: begin
               if (w.char_code == CH_0 && !w.is_last) begin
                  radix_q = RADIX_OCT;
                  phase_q = PH_SECOND;
               end else begin
                  radix_q = RADIX_DEC;
                  phase_q = PH_DIGITS;
                  take_digit_char(w.char_code);
               end
            end
            PH_SECOND: begin
               if ((w.char_code == CH_LO_X || w.char_code == CH_UP_X) && !w.is_last) begin
                  radix_q = RADIX_HEX;
                  phase_q = PH_DIGITS;
               end else begin
                  phase_q = PH_DIGITS;
                  take_digit_char(w.char_code);
               end
            end
            PH_DIGITS: take_digit_char(w.char_code);
            default:   take_suffix_char(w.char_code);
         endcase
      end
      if (w.is_last) begin
         if (bad_q)
            expected_constants.push_back('{value: '0, unsigned_flag: 1'b0, status: ST_INVALID});
         else
            expected_constants.push_back('{value: acc_q,
                                          unsigned_flag: saw_u_q || acc_q > SignedMax,
                                          status: ovf_q ? ST_TOO_LARGE : ST_OK});
         acc_q = '0;
         radix_q = RADIX_DEC;
         phase_q = PH_FIRST;
         saw_u_q = 1'b0;
         saw_l_q = 1'b0;
         lpend_q = LP_NONE;
         ovf_q = 1'b0;
         bad_q = 1'b0;
      end
   endfunction

   function automatic char_q_type text_chars(string s);
      char_q_type t;
      for (int i = 0; i < s.len(); i++)
         t.push_back(s[i]);
      return t;
   endfunction

   function automatic char_q_type make_token();
      char_q_type t;
      int unsigned kind;
      int unsigned len;
      int unsigned pick;
      int unsigned l_sel;
      logic        use_u;
      logic        u_first;
      logic [7:0]  u_char;
      logic [7:0]  l_char;
      kind = $urandom_range(99);
      len = ($urandom_range(3) == 0) ? $urandom_range(24) : $urandom_range(5);
      if (kind >= 86) begin
         repeat ($urandom_range(1, 6))
            t.push_back(8'($urandom_range(255)));
         return t;
      end
      if (kind < 6) begin
         t = text_chars(extreme_texts[$urandom_range(8)]);
      end else if (kind < 36) begin
         t.push_back(CH_0 + 8'($urandom_range(1, 9)));
         repeat (len)
            t.push_back(CH_0 + 8'($urandom_range(9)));
      end else if (kind < 56) begin
         t.push_back(CH_0);
         repeat (len)
            t.push_back(CH_0 + 8'($urandom_range(7)));
      end else begin
         t.push_back(CH_0);
         t.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
         repeat (len) begin
            pick = $urandom_range(15);
            if (pick < 10)
               t.push_back(CH_0 + 8'(pick));
            else
               t.push_back(($urandom_range(1) ? CH_LO_A : CH_UP_A) + 8'(pick - 10));
         end
      end
      use_u = ($urandom_range(2) != 0);
      l_sel = $urandom_range(4);
      u_first = 1'($urandom_range(1));
      u_char = $urandom_range(1) ? CH_LO_U : CH_UP_U;
      l_char = $urandom_range(1) ? CH_LO_L : CH_UP_L;
      if (use_u && u_first)
         t.push_back(u_char);
      repeat ((l_sel > 2) ? 2 : (l_sel != 0) ? 1 : 0)
         t.push_back(l_char);
      if (use_u && !u_first)
         t.push_back(u_char);
      if ($urandom_range(99) < 15) begin
         pick = $urandom_range(t.size());
         if (pick == t.size())
            t.push_back(8'($urandom_range(255)));
         else if ($urandom_range(1))
            t[pick] = 8'($urandom_range(255));
         else
            t.insert(pick, 8'($urandom_range(255)));
      end
      return t;
   endfunction

   task automatic send_char(logic [7:0] ch, logic is_final);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(negedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_word <= '{char_code: ch, is_last: is_final};
      do
         @(posedge clock);
      while (req_stall);
      parse_char('{char_code: ch, is_last: is_final});
      chars_sent++;
   endtask

   task automatic send_token(char_q_type t);
      for (int i = 0; i < t.size(); i++)
         send_char(t[i], i == t.size() - 1);
   endtask

   task automatic wait_for_constants();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_constants.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic test_special_tokens();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_token(text_chars("9"));
      send_token(text_chars("0"));
      send_token(text_chars("0x"));
      send_token(text_chars("0Xu"));
      send_token(text_chars("08"));
      send_token(text_chars("1f"));
      send_token(text_chars("7LLU"));
      send_token(text_chars("5lL"));
      send_token(text_chars("1uu9"));
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
      wait_for_constants();
   endtask

   task automatic test_random_tokens(int unsigned send_pct, int unsigned stall_pct,
                                     int unsigned count);
      int unsigned stop_at;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      stop_at = chars_sent + count;
      while (chars_sent < stop_at)
         send_token(make_token());
      wait_for_constants();
   endtask

   task automatic test_result_hold_off();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      hold_requests++;
      repeat (40)
         send_char(CH_0 + 8'($urandom_range(9)), 1'b1);
      wait_for_constants();
   endtask

   task automatic test_pause_between_tokens();
      send_idle_pct = 29;
      rsp_stall_pct = 29;
      repeat (6) begin
         send_token(make_token());
         wait_for_constants();
      end
   endtask

   // receiver: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left <= HoldOffCycles;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_constants.size() == 0) begin
            $error("constant %h with no token behind it", rsp_word.value);
            failures++;
         end else begin
            want = expected_constants.pop_front();
            if (rsp_word.value !== want.value) begin
               $error("value: expected %h, actual %h", want.value, rsp_word.value);
               failures++;
            end
            if (rsp_word.unsigned_flag !== want.unsigned_flag) begin
               $error("unsigned_flag: expected %b, actual %b", want.unsigned_flag,
                      rsp_word.unsigned_flag);
               failures++;
            end
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_word.status);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_special_tokens();
      test_random_tokens(0, 0, 360);
      test_random_tokens(58, 0, 400);
      test_random_tokens(0, 58, 400);
      test_random_tokens(29, 29, 400);
      test_result_hold_off();
      test_pause_between_tokens();
      repeat (8) @(negedge clock);
      if (expected_constants.size() != 0) begin
         $error("%0d constants never came out", expected_constants.size());
         failures++;
      end
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
